// File: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/amcv_pkg.sv
// ----------------------------------------------------------------------------
// amcv_pkg
// Shared types, codes and constants of the archive member chain validator.
// ----------------------------------------------------------------------------
`default_nettype none

package amcv_pkg;

  localparam int unsigned MAX_MEMBERS  = 100000;
  localparam int unsigned HEADER_BYTES = 48;

  localparam logic [5:0]  HDR_LAST  = 6'(HEADER_BYTES - 1);
  localparam logic [31:0] USIZE_CAP = 32'h1000_0000;
  localparam logic [31:0] TAG_VALUE = 32'h0000_0130;

  localparam logic [7:0] MAGIC_0 = 8'h1a;
  localparam logic [7:0] MAGIC_1 = 8'h45;
  localparam logic [7:0] MAGIC_2 = 8'h41;

  localparam logic [1:0] KIND_MEMBER   = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_TRUNCATED = 4'd1;
  localparam logic [3:0] ERR_MAGIC     = 4'd2;
  localparam logic [3:0] ERR_TAG       = 4'd3;
  localparam logic [3:0] ERR_METHOD    = 4'd4;
  localparam logic [3:0] ERR_NEGATIVE  = 4'd5;
  localparam logic [3:0] ERR_TOO_LARGE = 4'd6;
  localparam logic [3:0] ERR_NAME      = 4'd7;
  localparam logic [3:0] ERR_PAST_END  = 4'd8;
  localparam logic [3:0] ERR_STORED    = 4'd9;
  localparam logic [3:0] ERR_TOO_MANY  = 4'd10;

  typedef struct packed {
    logic        magic_bad;
    logic [3:0]  name_count;
    logic        name_nul;
    logic        name_bad;
    logic [31:0] stamp;
    logic [7:0]  method_byte;
    logic [31:0] usize;
    logic [31:0] csize;
    logic [31:0] tag;
  } hdr_fields_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [3:0]  error_code;
    logic [16:0] member_index;
    logic [31:0] header_offset;
    logic        method_code;
    logic [30:0] packed_size;
    logic [28:0] unpacked_size;
    logic [31:0] stamp_word;
    logic [3:0]  name_length;
    logic        chain_complete;
  } result_t;

  typedef struct packed {
    logic is_error;
    logic is_complete;
  } check_status_t;

  function automatic result_t make_error(logic [3:0] code, logic [16:0] index,
                                         logic [31:0] offset);
    result_t r;
    r = '0;
    r.record_kind   = KIND_ERROR;
    r.error_code    = code;
    r.member_index  = index;
    r.header_offset = offset;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/amcv_hdr_capture.sv
// ----------------------------------------------------------------------------
// amcv_hdr_capture
// Captures the header fields of one member, one byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

module amcv_hdr_capture import amcv_pkg::*; (
  input  logic        clk,
  input  logic        load,
  input  logic [5:0]  pos,
  input  logic [7:0]  data_byte,
  output hdr_fields_t fields
);

  hdr_fields_t fields_next;
  logic        bad_char;
  logic [1:0]  usize_idx;
  logic [1:0]  csize_idx;
  logic [1:0]  tag_idx;

  always_comb begin
    usize_idx = 2'(pos - 6'd21);
    csize_idx = 2'(pos - 6'd25);
    tag_idx   = 2'(pos - 6'd29);
    bad_char  = !(data_byte inside {[8'h20:8'h7e]}) ||
                (data_byte inside {8'h2f, 8'h5c, 8'h3a});
    fields_next = fields;
    if (pos == 6'd0) begin
      fields_next = '0;
    end
    case (pos)
      6'd0: fields_next.magic_bad = (data_byte != MAGIC_0);
      6'd1: fields_next.magic_bad = fields.magic_bad || (data_byte != MAGIC_1);
      6'd2: fields_next.magic_bad = fields.magic_bad || (data_byte != MAGIC_2);
      default: ;
    endcase
    if (pos inside {[6'd3:6'd14]}) begin
      if (!fields.name_nul) begin
        if (data_byte == 8'h00) begin
          fields_next.name_nul = 1'b1;
        end else begin
          fields_next.name_count = fields.name_count + 4'd1;
          fields_next.name_bad   = fields.name_bad || bad_char;
        end
      end else if (data_byte != 8'h00) begin
        fields_next.name_bad = 1'b1;
      end
    end
    if (pos inside {[6'd16:6'd19]}) begin
      fields_next.stamp[{pos[1:0], 3'b000} +: 8] = data_byte;
    end
    if (pos == 6'd20) begin
      fields_next.method_byte = data_byte;
    end
    if (pos inside {[6'd21:6'd24]}) begin
      fields_next.usize[{usize_idx, 3'b000} +: 8] = data_byte;
    end
    if (pos inside {[6'd25:6'd28]}) begin
      fields_next.csize[{csize_idx, 3'b000} +: 8] = data_byte;
    end
    if (pos inside {[6'd29:6'd32]}) begin
      fields_next.tag[{tag_idx, 3'b000} +: 8] = data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fields <= fields_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/amcv_hdr_check.sv
// ----------------------------------------------------------------------------
// amcv_hdr_check
// Validates a captured header in priority order and forms its record.
// ----------------------------------------------------------------------------
`default_nettype none

module amcv_hdr_check import amcv_pkg::*; (
  input  hdr_fields_t   fields,
  input  logic [32:0]   data_off,
  input  logic [31:0]   member_start,
  input  logic [16:0]   members_seen,
  input  logic [31:0]   size_limit,
  output result_t       res,
  output check_status_t status
);

  logic [33:0] data_end;
  logic [3:0]  code;

  always_comb begin
    data_end = {1'b0, data_off} + {2'b00, fields.csize};
    if (fields.magic_bad) begin
      code = ERR_MAGIC;
    end else if (fields.tag != TAG_VALUE) begin
      code = ERR_TAG;
    end else if (fields.method_byte > 8'd1) begin
      code = ERR_METHOD;
    end else if (fields.usize[31] || fields.csize[31]) begin
      code = ERR_NEGATIVE;
    end else if (fields.usize > USIZE_CAP) begin
      code = ERR_TOO_LARGE;
    end else if (fields.name_count == 4'd0 || fields.name_bad) begin
      code = ERR_NAME;
    end else if (data_end > {2'b00, size_limit}) begin
      code = ERR_PAST_END;
    end else if (fields.method_byte == 8'd0 && fields.csize != fields.usize) begin
      code = ERR_STORED;
    end else begin
      code = ERR_NONE;
    end

    status.is_error    = (code != ERR_NONE);
    status.is_complete = (code == ERR_NONE) && (data_end == {2'b00, size_limit});

    if (status.is_error) begin
      res = make_error(code, members_seen, member_start);
    end else begin
      res.record_kind    = status.is_complete ? KIND_COMPLETE : KIND_MEMBER;
      res.error_code     = ERR_NONE;
      res.member_index   = members_seen;
      res.header_offset  = member_start;
      res.method_code    = fields.method_byte[0];
      res.packed_size    = fields.csize[30:0];
      res.unpacked_size  = fields.usize[28:0];
      res.stamp_word     = fields.stamp;
      res.name_length    = fields.name_count;
      res.chain_complete = status.is_complete;
    end
  end

endmodule

`default_nettype wire

// File: sv/amcv_out_buf.sv
// ----------------------------------------------------------------------------
// amcv_out_buf
// Output register with a skid stage; full tells the producer to hold.
// ----------------------------------------------------------------------------
`default_nettype none

module amcv_out_buf import amcv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t out_data,
  output logic    full
);

  logic    skid_valid;
  result_t skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_data  <= push_data;
        out_valid <= push;
      end
    end else if (push) begin
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: sv/archive_member_chain_validator.sv
// ----------------------------------------------------------------------------
// archive_member_chain_validator
// Follows the member chain of a byte-serial archive and reports each member,
// the end of the chain, or the first error found.
// ----------------------------------------------------------------------------
//  channel   signals                         direction  payload
//  input     in_valid / in_stall             in         data_byte
//  config    cfg_valid / cfg_ready           in         total_size
//  output    out_valid / out_stall           out        record fields
//
//  One byte per cycle while in_stall is low; a header is checked in the cycle
//  its last byte lands. Results pass through an output register and a skid
//  stage, so in_stall rises only once both hold a record.
//  Reset is synchronous; it clears the parse and sets the size to zero.
//  Writing total_size restarts the parse.
// ----------------------------------------------------------------------------
`default_nettype none

module archive_member_chain_validator import amcv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] total_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  record_kind,
  output logic [3:0]  error_code,
  output logic [16:0] member_index,
  output logic [31:0] header_offset,
  output logic        method_code,
  output logic [30:0] packed_size,
  output logic [28:0] unpacked_size,
  output logic [31:0] stamp_word,
  output logic [3:0]  name_length,
  output logic        chain_complete
);

  logic [31:0] size_limit;
  logic [32:0] stream_offset, stream_offset_next;
  logic [31:0] member_start, member_start_next;
  logic [32:0] data_off, data_off_next;
  logic [5:0]  hdr_pos, hdr_pos_next;
  logic        in_data, in_data_next;
  logic [30:0] data_left, data_left_next;
  logic [16:0] members_seen, members_seen_next;
  logic        halted, halted_next;

  logic          accept;
  logic          load;
  logic          push;
  result_t       push_data;
  result_t       head;
  hdr_fields_t   fields;
  result_t       check_res;
  check_status_t check_status;
  logic          buf_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign accept    = in_valid && !in_stall;

  amcv_hdr_capture u_capture (
    .clk       (clk),
    .load      (load),
    .pos       (hdr_pos),
    .data_byte (data_byte),
    .fields    (fields)
  );

  amcv_hdr_check u_check (
    .fields       (fields),
    .data_off     (data_off),
    .member_start (member_start),
    .members_seen (members_seen),
    .size_limit   (size_limit),
    .res          (check_res),
    .status       (check_status)
  );

  always_comb begin
    stream_offset_next = stream_offset;
    member_start_next  = member_start;
    data_off_next      = data_off;
    hdr_pos_next       = hdr_pos;
    in_data_next       = in_data;
    data_left_next     = data_left;
    members_seen_next  = members_seen;
    halted_next        = halted;
    load               = 1'b0;
    push               = 1'b0;
    push_data          = check_res;

    if (accept && !halted) begin
      if (in_data) begin
        stream_offset_next = stream_offset + 33'd1;
        data_left_next     = data_left - 31'd1;
        in_data_next       = (data_left != 31'd1);
      end else if (hdr_pos == 6'd0 && members_seen >= 17'(MAX_MEMBERS)) begin
        push        = 1'b1;
        push_data   = make_error(ERR_TOO_MANY, members_seen, stream_offset[31:0]);
        halted_next = 1'b1;
      end else if (hdr_pos == 6'd0 &&
                   ({1'b0, stream_offset} + 34'(HEADER_BYTES)) > {2'b00, size_limit}) begin
        push        = 1'b1;
        push_data   = make_error(ERR_TRUNCATED, members_seen, stream_offset[31:0]);
        halted_next = 1'b1;
      end else begin
        load               = 1'b1;
        stream_offset_next = stream_offset + 33'd1;
        hdr_pos_next       = hdr_pos + 6'd1;
        if (hdr_pos == 6'd0) begin
          member_start_next = stream_offset[31:0];
          data_off_next     = {1'b0, stream_offset[31:0]} + 33'(HEADER_BYTES);
        end
        if (hdr_pos == HDR_LAST) begin
          hdr_pos_next = 6'd0;
          push         = 1'b1;
          if (check_status.is_error) begin
            halted_next = 1'b1;
          end else begin
            members_seen_next = members_seen + 17'd1;
            if (check_status.is_complete) begin
              halted_next = 1'b1;
            end else if (fields.csize != 32'd0) begin
              in_data_next   = 1'b1;
              data_left_next = fields.csize[30:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit    <= '0;
      stream_offset <= '0;
      member_start  <= '0;
      data_off      <= '0;
      hdr_pos       <= '0;
      in_data       <= 1'b0;
      data_left     <= '0;
      members_seen  <= '0;
      halted        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      size_limit    <= total_size;
      stream_offset <= '0;
      member_start  <= '0;
      data_off      <= '0;
      hdr_pos       <= '0;
      in_data       <= 1'b0;
      data_left     <= '0;
      members_seen  <= '0;
      halted        <= 1'b0;
    end else begin
      stream_offset <= stream_offset_next;
      member_start  <= member_start_next;
      data_off      <= data_off_next;
      hdr_pos       <= hdr_pos_next;
      in_data       <= in_data_next;
      data_left     <= data_left_next;
      members_seen  <= members_seen_next;
      halted        <= halted_next;
    end
  end

  amcv_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (head),
    .full      (buf_full)
  );

  assign record_kind    = head.record_kind;
  assign error_code     = head.error_code;
  assign member_index   = head.member_index;
  assign header_offset  = head.header_offset;
  assign method_code    = head.method_code;
  assign packed_size    = head.packed_size;
  assign unpacked_size  = head.unpacked_size;
  assign stamp_word     = head.stamp_word;
  assign name_length    = head.name_length;
  assign chain_complete = head.chain_complete;

endmodule

`default_nettype wire

// File: sv/amcv_checker.sv
// ----------------------------------------------------------------------------
// amcv_checker
// Port-level checks on the records leaving the validator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module amcv_checker import amcv_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  record_kind,
  input logic [3:0]  error_code,
  input logic [30:0] packed_size,
  input logic [28:0] unpacked_size,
  input logic [3:0]  name_length,
  input logic        method_code,
  input logic        chain_complete
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(record_kind) && $stable(error_code) && $stable(packed_size), "stalled request changed")

  `ASSERT_SAME(a_complete_flag, clk, rst, out_valid, chain_complete == (record_kind == KIND_COMPLETE), "chain_complete disagrees with record kind")

  `ASSERT_SAME(a_error_clean, clk, rst, out_valid && record_kind == KIND_ERROR, error_code != ERR_NONE && method_code == 1'b0 && packed_size == '0 && unpacked_size == '0 && name_length == 4'd0, "error request carries member fields")

  `ASSERT_SAME(a_member_ok, clk, rst, out_valid && record_kind != KIND_ERROR, error_code == ERR_NONE && name_length != 4'd0 && name_length <= 4'd12, "member request malformed")

endmodule

bind archive_member_chain_validator amcv_checker u_amcv_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .record_kind    (record_kind),
  .error_code     (error_code),
  .packed_size    (packed_size),
  .unpacked_size  (unpacked_size),
  .name_length    (name_length),
  .method_code    (method_code),
  .chain_complete (chain_complete)
);

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the archive member chain validator. Archives are
// streamed in one byte per request: first a table of hand-picked archives
// (size extremes, every error code but the member limit, name corner cases,
// multi-member chains), then random chains that are mostly well formed,
// with flawed headers, short sizes and raw noise mixed in. A predictor walks
// every byte and queues the records it expects; each record leaving the
// block is compared field by field. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import amcv_pkg::*;

  localparam int ITEM_GOAL      = 1600;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int NUM_CASES      = 26;

  typedef enum logic [3:0] {
    FLAW_NONE,
    FLAW_NAME_FULL,
    FLAW_MAGIC0,
    FLAW_MAGIC2,
    FLAW_TAG,
    FLAW_NAME_EMPTY,
    FLAW_NAME_SLASH,
    FLAW_NAME_BSLASH,
    FLAW_NAME_COLON,
    FLAW_NAME_LOW,
    FLAW_NAME_HIGH,
    FLAW_NAME_TAIL,
    FLAW_NOISE
  } hdr_flaw_e;

  typedef struct packed {
    logic [31:0] arch;
    hdr_flaw_e   flaw;
    logic [7:0]  meth;
    logic [31:0] usz;
    logic [31:0] csz;
    logic [2:0]  copies;
    logic [3:0]  typed_code;
  } chain_case_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] total_size = 32'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  record_kind;
  logic [3:0]  error_code;
  logic [16:0] member_index;
  logic [31:0] header_offset;
  logic        method_code;
  logic [30:0] packed_size;
  logic [28:0] unpacked_size;
  logic [31:0] stamp_word;
  logic [3:0]  name_length;
  logic        chain_complete;

  archive_member_chain_validator dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .total_size    (total_size),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .record_kind   (record_kind),
    .error_code    (error_code),
    .member_index  (member_index),
    .header_offset (header_offset),
    .method_code   (method_code),
    .packed_size   (packed_size),
    .unpacked_size (unpacked_size),
    .stamp_word    (stamp_word),
    .name_length   (name_length),
    .chain_complete(chain_complete)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [31:0] arch_len;
  logic [32:0] cursor;
  logic [31:0] hdr_base;
  logic [5:0]  hdr_pos;
  logic        skipping;
  logic [30:0] skip_left;
  logic [7:0]  meth_b;
  logic [31:0] usz_w;
  logic [31:0] csz_w;
  logic [31:0] tag_w;
  logic [31:0] stamp_w;
  logic [3:0]  name_len;
  logic        name_nul;
  logic        name_bad;
  logic        magic_err;
  logic [16:0] members;
  logic        parse_done;

  result_t     pending_records[$];
  logic [7:0]  archive_bytes[$];
  int          fault_count = 0;
  int          fed_items = 0;
  int          idle_cycles = 0;
  bit          feed_calm = 1'b0;
  bit          sink_calm = 1'b0;

  chain_case_t directed_cases [NUM_CASES] = '{
    '{32'd0,        FLAW_NONE,        8'd1,   32'd10,         32'd10,         3'd1, ERR_TRUNCATED},
    '{32'd47,       FLAW_NONE,        8'd1,   32'd10,         32'd10,         3'd1, ERR_TRUNCATED},
    '{32'd48,       FLAW_NONE,        8'd1,   32'd0,          32'd0,          3'd1, ERR_NONE},
    '{32'd68,       FLAW_NONE,        8'd0,   32'd20,         32'd20,         3'd1, ERR_NONE},
    '{32'd272,      FLAW_NONE,        8'd1,   32'd500,        32'd20,         3'd4, ERR_NONE},
    '{32'd100,      FLAW_NONE,        8'd1,   32'd5,          32'd20,         3'd2, ERR_NONE},
    '{32'd1000,     FLAW_MAGIC0,      8'd1,   32'd0,          32'd0,          3'd1, ERR_MAGIC},
    '{32'd1000,     FLAW_MAGIC2,      8'd1,   32'd0,          32'd0,          3'd1, ERR_MAGIC},
    '{32'd1000,     FLAW_TAG,         8'd1,   32'd0,          32'd0,          3'd1, ERR_TAG},
    '{32'd1000,     FLAW_NONE,        8'd2,   32'd0,          32'd0,          3'd1, ERR_METHOD},
    '{32'd1000,     FLAW_NONE,        8'hff,  32'd0,          32'd0,          3'd1, ERR_METHOD},
    '{32'd1000,     FLAW_NONE,        8'd1,   32'h8000_0000,  32'd0,          3'd1, ERR_NEGATIVE},
    '{32'd1000,     FLAW_NONE,        8'd1,   32'd0,          32'hffff_ffff,  3'd1, ERR_NEGATIVE},
    '{32'd1000,     FLAW_NONE,        8'd1,   32'h1000_0001,  32'd0,          3'd1, ERR_TOO_LARGE},
    '{32'd1000,     FLAW_NONE,        8'd1,   32'h1000_0000,  32'd0,          3'd1, ERR_NONE},
    '{32'd1000,     FLAW_NAME_EMPTY,  8'd1,   32'd0,          32'd0,          3'd1, ERR_NAME},
    '{32'd1000,     FLAW_NAME_SLASH,  8'd1,   32'd0,          32'd0,          3'd1, ERR_NAME},
    '{32'd1000,     FLAW_NAME_BSLASH, 8'd1,   32'd0,          32'd0,          3'd1, ERR_NAME},
    '{32'd1000,     FLAW_NAME_COLON,  8'd1,   32'd0,          32'd0,          3'd1, ERR_NAME},
    '{32'd1000,     FLAW_NAME_LOW,    8'd1,   32'd0,          32'd0,          3'd1, ERR_NAME},
    '{32'd1000,     FLAW_NAME_HIGH,   8'd1,   32'd0,          32'd0,          3'd1, ERR_NAME},
    '{32'd1000,     FLAW_NAME_TAIL,   8'd1,   32'd0,          32'd0,          3'd1, ERR_NAME},
    '{32'd60,       FLAW_NAME_FULL,   8'd1,   32'd12,         32'd12,         3'd1, ERR_NONE},
    '{32'd100,      FLAW_NONE,        8'd1,   32'd0,          32'd53,         3'd1, ERR_PAST_END},
    '{32'd1000,     FLAW_NONE,        8'd0,   32'd7,          32'd8,          3'd1, ERR_STORED},
    '{32'hffff_ffff, FLAW_NONE,       8'd1,   32'h0fff_ffff,  32'h7fff_ffff,  3'd1, ERR_NONE}
  };

  task automatic clear_chain();
    cursor     = '0;
    hdr_base   = '0;
    hdr_pos    = '0;
    skipping   = 1'b0;
    skip_left  = '0;
    meth_b     = '0;
    usz_w      = '0;
    csz_w      = '0;
    tag_w      = '0;
    stamp_w    = '0;
    name_len   = '0;
    name_nul   = 1'b0;
    name_bad   = 1'b0;
    magic_err  = 1'b0;
    members    = '0;
    parse_done = 1'b0;
  endtask

  task automatic halt_with_error(input logic [3:0] code, input logic [31:0] offset,
                                 output result_t rec);
    rec = '0;
    rec.record_kind   = KIND_ERROR;
    rec.error_code    = code;
    rec.member_index  = members;
    rec.header_offset = offset;
    parse_done = 1'b1;
  endtask

  task automatic grab_header_byte(input int p, input logic [7:0] b);
    if (p == 0 && b != MAGIC_0) magic_err = 1'b1;
    if (p == 1 && b != MAGIC_1) magic_err = 1'b1;
    if (p == 2 && b != MAGIC_2) magic_err = 1'b1;
    if (p >= 3 && p < 15) begin
      if (!name_nul) begin
        if (b == 8'h00) begin
          name_nul = 1'b1;
        end else begin
          name_len = name_len + 1'b1;
          if (b < 8'h20 || b > 8'h7e || b == 8'h2f || b == 8'h5c || b == 8'h3a)
            name_bad = 1'b1;
        end
      end else if (b != 8'h00) begin
        name_bad = 1'b1;
      end
    end
    if (p >= 16 && p < 20) stamp_w[8*(p-16) +: 8] = b;
    if (p == 20) meth_b = b;
    if (p >= 21 && p < 25) usz_w[8*(p-21) +: 8] = b;
    if (p >= 25 && p < 29) csz_w[8*(p-25) +: 8] = b;
    if (p >= 29 && p < 33) tag_w[8*(p-29) +: 8] = b;
  endtask

  task automatic judge_header(output result_t rec);
    longint unsigned body_at;
    logic [3:0]      code;
    body_at = 64'(hdr_base) + HEADER_BYTES;
    code = ERR_NONE;
    if (magic_err) code = ERR_MAGIC;
    else if (tag_w != TAG_VALUE) code = ERR_TAG;
    else if (meth_b > 8'd1) code = ERR_METHOD;
    else if (usz_w[31] || csz_w[31]) code = ERR_NEGATIVE;
    else if (usz_w > USIZE_CAP) code = ERR_TOO_LARGE;
    else if (name_len == 0 || name_bad) code = ERR_NAME;
    else if (body_at > 64'(arch_len) || 64'(csz_w) > 64'(arch_len) - body_at)
      code = ERR_PAST_END;
    else if (meth_b == 8'd0 && csz_w != usz_w) code = ERR_STORED;
    if (code != ERR_NONE) begin
      halt_with_error(code, hdr_base, rec);
      return;
    end
    rec = '0;
    rec.error_code    = ERR_NONE;
    rec.member_index  = members;
    rec.header_offset = hdr_base;
    rec.method_code   = meth_b[0];
    rec.packed_size   = csz_w[30:0];
    rec.unpacked_size = usz_w[28:0];
    rec.stamp_word    = stamp_w;
    rec.name_length   = name_len;
    members = members + 1'b1;
    if (body_at + 64'(csz_w) == 64'(arch_len)) begin
      rec.record_kind    = KIND_COMPLETE;
      rec.chain_complete = 1'b1;
      parse_done = 1'b1;
    end else begin
      rec.record_kind = KIND_MEMBER;
      if (csz_w != 0) begin
        skipping  = 1'b1;
        skip_left = csz_w[30:0];
      end
    end
  endtask

  task automatic walk_chain_byte(input logic [7:0] b, output bit made,
                                 output result_t rec, output bit ignored);
    longint unsigned here;
    made = 1'b0;
    rec = '0;
    ignored = parse_done;
    if (parse_done) return;
    if (skipping) begin
      cursor = cursor + 1'b1;
      skip_left = skip_left - 1'b1;
      if (skip_left == 0) skipping = 1'b0;
      return;
    end
    if (hdr_pos == 0) begin
      here = 64'(cursor);
      if (members >= MAX_MEMBERS) begin
        halt_with_error(ERR_TOO_MANY, cursor[31:0], rec);
        made = 1'b1;
        return;
      end
      if (here > 64'(arch_len) || 64'(HEADER_BYTES) > 64'(arch_len) - here) begin
        halt_with_error(ERR_TRUNCATED, cursor[31:0], rec);
        made = 1'b1;
        return;
      end
      hdr_base  = cursor[31:0];
      meth_b    = '0;
      usz_w     = '0;
      csz_w     = '0;
      tag_w     = '0;
      stamp_w   = '0;
      name_len  = '0;
      name_nul  = 1'b0;
      name_bad  = 1'b0;
      magic_err = 1'b0;
    end
    grab_header_byte(int'(hdr_pos), b);
    cursor = cursor + 1'b1;
    hdr_pos = hdr_pos + 1'b1;
    if (hdr_pos == HEADER_BYTES) begin
      hdr_pos = '0;
      judge_header(rec);
      made = 1'b1;
    end
  endtask

  task automatic append_member(input logic [7:0] meth, input logic [31:0] usz,
                               input logic [31:0] csz, input hdr_flaw_e flaw);
    logic [7:0]  hdr [HEADER_BYTES];
    logic [31:0] tag;
    logic [31:0] stamp;
    logic [7:0]  ch;
    int          nlen;
    int          body;
    tag = TAG_VALUE;
    stamp = $urandom;
    nlen = (flaw == FLAW_NAME_FULL) ? 12 : $urandom_range(1, 12);
    for (int i = 0; i < HEADER_BYTES; i++) hdr[i] = 8'($urandom);
    hdr[0] = MAGIC_0;
    hdr[1] = MAGIC_1;
    hdr[2] = MAGIC_2;
    for (int i = 0; i < 12; i++) begin
      do ch = 8'($urandom_range(8'h20, 8'h7e));
      while (ch == 8'h2f || ch == 8'h5c || ch == 8'h3a);
      hdr[3+i] = (i < nlen) ? ch : 8'h00;
    end
    for (int i = 0; i < 4; i++) begin
      hdr[16+i] = stamp[8*i +: 8];
      hdr[21+i] = usz[8*i +: 8];
      hdr[25+i] = csz[8*i +: 8];
      hdr[29+i] = tag[8*i +: 8];
    end
    hdr[20] = meth;
    case (flaw)
      FLAW_NAME_FULL: begin
        hdr[3] = 8'h20;
        hdr[14] = 8'h7e;
      end
      FLAW_MAGIC0: hdr[0] = 8'h1b;
      FLAW_MAGIC2: hdr[2] = 8'h00;
      FLAW_TAG: hdr[29] = 8'h31;
      FLAW_NAME_EMPTY: for (int i = 3; i < 15; i++) hdr[i] = 8'h00;
      FLAW_NAME_SLASH: hdr[3] = 8'h2f;
      FLAW_NAME_BSLASH: hdr[3] = 8'h5c;
      FLAW_NAME_COLON: hdr[3] = 8'h3a;
      FLAW_NAME_LOW: hdr[3] = 8'h1f;
      FLAW_NAME_HIGH: hdr[3] = 8'h7f;
      FLAW_NAME_TAIL: begin
        hdr[3] = 8'h61;
        hdr[4] = 8'h00;
        hdr[14] = 8'h62;
      end
      FLAW_NOISE: hdr[$urandom_range(0, HEADER_BYTES - 1)] = 8'($urandom);
      default: ;
    endcase
    for (int i = 0; i < HEADER_BYTES; i++) archive_bytes.push_back(hdr[i]);
    body = (csz > 64) ? 16 : int'(csz);
    repeat (body) archive_bytes.push_back(8'($urandom));
  endtask

  task automatic run_archive(input logic [31:0] arch, input logic [3:0] typed_code);
    result_t rec;
    result_t typed_rec;
    bit      made;
    bit      ignored;
    int      gap;
    typed_rec = '0;
    typed_rec.record_kind = KIND_ERROR;
    typed_rec.error_code  = typed_code;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid  <= 1'b1;
    total_size <= arch;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    arch_len = arch;
    clear_chain();
    feed_calm = ($urandom_range(0, 3) == 0);
    sink_calm = ($urandom_range(0, 3) == 0);
    foreach (archive_bytes[i]) begin
      walk_chain_byte(archive_bytes[i], made, rec, ignored);
      if (made) pending_records.push_back((typed_code != ERR_NONE) ? typed_rec : rec);
      if (!ignored) fed_items++;
      gap = feed_calm ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid  <= 1'b1;
      data_byte <= archive_bytes[i];
      do @(posedge clk); while (in_stall);
    end
    in_valid <= 1'b0;
    archive_bytes.delete();
  endtask

  task automatic random_archive();
    int          mode;
    int          count;
    int          bad_at;
    logic [31:0] len_sum;
    logic [31:0] arch;
    logic [7:0]  meth;
    logic [31:0] usz;
    logic [31:0] csz;
    hdr_flaw_e   flaw;
    mode = $urandom_range(0, 9);
    count = $urandom_range(1, 6);
    bad_at = (mode == 7) ? $urandom_range(0, count - 1) : -1;
    len_sum = '0;
    if (mode == 9) begin
      repeat ($urandom_range(48, 120)) archive_bytes.push_back(8'($urandom));
    end else begin
      for (int m = 0; m < count; m++) begin
        meth = 8'($urandom_range(0, 1));
        csz = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 40));
        if (meth == 8'd0) begin
          usz = csz;
        end else begin
          case ($urandom_range(0, 3))
            0: usz = USIZE_CAP;
            1: usz = $urandom_range(0, USIZE_CAP);
            default: usz = $urandom_range(0, 2000);
          endcase
        end
        if (m == bad_at) flaw = hdr_flaw_e'($urandom_range(FLAW_MAGIC0, FLAW_NOISE));
        else flaw = ($urandom_range(0, 3) == 0) ? FLAW_NAME_FULL : FLAW_NONE;
        append_member(meth, usz, csz, flaw);
        len_sum = len_sum + HEADER_BYTES + csz;
      end
    end
    case (mode)
      6: arch = len_sum + $urandom_range(1, 47);
      8: arch = $urandom;
      9: arch = $urandom_range(0, 400);
      default: arch = len_sum;
    endcase
    run_archive(arch, ERR_NONE);
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= 10)
        $display("mismatch %s: expected %0h, got %0h", label, want, got);
    end
  endtask

  initial begin : sink
    int hold;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        hold = sink_calm ? 0 : $urandom_range(0, 13);
        if (hold != 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : record_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_records.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected record: kind %0d code %0d", record_kind, error_code);
      end else begin
        want = pending_records.pop_front();
        check_field("record_kind", want.record_kind, record_kind);
        check_field("error_code", want.error_code, error_code);
        check_field("member_index", want.member_index, member_index);
        check_field("header_offset", want.header_offset, header_offset);
        check_field("method_code", want.method_code, method_code);
        check_field("packed_size", want.packed_size, packed_size);
        check_field("unpacked_size", want.unpacked_size, unpacked_size);
        check_field("stamp_word", want.stamp_word, stamp_word);
        check_field("name_length", want.name_length, name_length);
        check_field("chain_complete", want.chain_complete, chain_complete);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d records pending", pending_records.size());
      $display("tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    arch_len = '0;
    clear_chain();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_cases[c]) begin
      repeat (directed_cases[c].copies)
        append_member(directed_cases[c].meth, directed_cases[c].usz,
                      directed_cases[c].csz, directed_cases[c].flaw);
      run_archive(directed_cases[c].arch, directed_cases[c].typed_code);
    end
    while (fed_items < ITEM_GOAL) random_archive();
    while (pending_records.size() != 0) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_records.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/amcv_pkg.sv
sv/amcv_hdr_capture.sv
sv/amcv_hdr_check.sv
sv/amcv_out_buf.sv
sv/archive_member_chain_validator.sv
sv/amcv_checker.sv
tb/tb.sv
